/* rtl/mckj_pkg.sv */
// Package with the sizes, field widths and state encoding of the k-jump minimum-cost block.
package mckj_pkg;

	localparam int MAX_JUMP    = 16;
	localparam int HEIGHT_BITS = 16;
	localparam int COST_W      = 32;
	localparam int CFG_W       = 5;

	localparam int ADDR_W      = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
	localparam int SEEN_W      = $clog2(MAX_JUMP + 1);
	localparam int ENTRY_W     = HEIGHT_BITS + COST_W;
	localparam int IN_TDATA_W  = ((HEIGHT_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((COST_W + 7) / 8) * 8;

	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [SEEN_W-1:0]      seen_t;
	typedef logic [HEIGHT_BITS-1:0] height_t;
	typedef logic [COST_W-1:0]      cost_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	// Step one slot back in the circular history, wrapping below zero.
	function automatic addr_t addr_prev(input addr_t a);
		addr_t r;
		if (a == '0) begin
			r = ADDR_W'(MAX_JUMP - 1);
		end else begin
			r = a - addr_t'(1);
		end
		return r;
	endfunction

	// Step one slot forward in the circular history, wrapping at the depth.
	function automatic addr_t addr_next(input addr_t a);
		addr_t r;
		if (a == ADDR_W'(MAX_JUMP - 1)) begin
			r = '0;
		end else begin
			r = a + addr_t'(1);
		end
		return r;
	endfunction

endpackage

/* rtl/mckj_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module mckj_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/min_cost_k_jump_path.sv */
// Streaming k-jump minimum-cost recurrence: one cost result per height item.
// Each item is accepted in IDLE, reads its reach = min(k, positions held) predecessors in
// READ, lets the last read land in WAIT and is stored in WRITE (straight from IDLE when
// reach is zero); one item at a time, through the single read port of the history RAM.
// arst_n clears the control state and sets k to 1; the history RAM is not cleared,
// since the held-position count keeps any unwritten entry from being read.
module min_cost_k_jump_path (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration: max_jump.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mckj_pkg::CFG_W-1:0]        cfg_data,
	// Input items.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mckj_pkg::IN_TDATA_W-1:0]   s_tdata,   // height
	input  logic                              s_tuser,   // starts_sequence
	input  logic                              s_tlast,   // last_item
	// Result items.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mckj_pkg::OUT_TDATA_W-1:0]  m_tdata,   // min_cost
	output logic                              m_tlast    // is_last
);

	// Configuration register; the user must write it only while the block is idle, the block itself does not enforce this.
	logic [mckj_pkg::CFG_W-1:0] max_jump_q;

	// Control state.
	mckj_pkg::state_t state_q;
	mckj_pkg::addr_t  wr_ptr_q;      // slot that the next position is written to
	mckj_pkg::addr_t  rd_ptr_q;      // slot of the predecessor read next
	mckj_pkg::seen_t  items_seen_q;  // positions held in the current sequence
	mckj_pkg::seen_t  reach_q;       // predecessors this item looks back at
	mckj_pkg::seen_t  cnt_q;         // predecessors already requested
	logic             seq_ended_q;
	logic             rd_vld_s1;     // RAM read data valid this cycle

	// Item being worked on.
	mckj_pkg::height_t h_q;
	logic              last_q;
	mckj_pkg::cost_t   best_q;

	// Output register.
	mckj_pkg::cost_t out_cost_q;
	logic            out_last_q;

	// RAM ports.
	logic                               ram_we;
	logic                               ram_re;
	logic [mckj_pkg::ENTRY_W-1:0]       ram_wdata;
	logic [mckj_pkg::ENTRY_W-1:0]       ram_rdata;

	logic              s_acc;
	logic              out_free;
	mckj_pkg::height_t h_in;
	mckj_pkg::seen_t   seen_eff;
	mckj_pkg::seen_t   k_eff;
	mckj_pkg::seen_t   reach_d;

	mckj_pkg::height_t prev_h;
	mckj_pkg::cost_t   prev_c;
	mckj_pkg::height_t diff;
	logic [mckj_pkg::COST_W:0] sum;
	mckj_pkg::cost_t   cand;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == mckj_pkg::ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;

	assign m_tdata = mckj_pkg::OUT_TDATA_W'(out_cost_q);
	assign m_tlast = out_last_q;

	assign h_in = s_tdata[mckj_pkg::HEIGHT_BITS-1:0];

	// A start mark, or the end of the previous sequence, drops all held positions.
	// The jump limit k treats zero as one and saturates at the history depth.
	always_comb begin
		seen_eff = (s_tuser || seq_ended_q) ? '0 : items_seen_q;
		if (max_jump_q == '0) begin
			k_eff = mckj_pkg::seen_t'(1);
		end else if (32'(max_jump_q) > 32'(mckj_pkg::MAX_JUMP)) begin
			k_eff = mckj_pkg::SEEN_W'(mckj_pkg::MAX_JUMP);
		end else begin
			k_eff = mckj_pkg::SEEN_W'(max_jump_q);
		end
		reach_d = (k_eff < seen_eff) ? k_eff : seen_eff;
	end

	// One shared add-compare unit: |h - h_prev| + cost_prev, saturated at the cost maximum.
	always_comb begin
		prev_h = ram_rdata[mckj_pkg::HEIGHT_BITS-1:0];
		prev_c = ram_rdata[mckj_pkg::ENTRY_W-1:mckj_pkg::HEIGHT_BITS];
		diff   = (h_q >= prev_h) ? (h_q - prev_h) : (prev_h - h_q);
		sum    = {1'b0, prev_c} + (mckj_pkg::COST_W + 1)'(diff);
		cand   = sum[mckj_pkg::COST_W] ? '1 : sum[mckj_pkg::COST_W-1:0];
	end

	assign ram_re    = (state_q == mckj_pkg::ST_READ);
	assign ram_we    = (state_q == mckj_pkg::ST_WRITE) && out_free;
	assign ram_wdata = {best_q, h_q};

	// The history is a circular buffer; the newest position sits just behind wr_ptr_q.
	mckj_ram #(
		.WIDTH (mckj_pkg::ENTRY_W),
		.DEPTH (mckj_pkg::MAX_JUMP)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_jump_q <= mckj_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			max_jump_q <= cfg_data;
		end
	end

	// Sequencer: accept an item, request each predecessor in turn from the newest back,
	// let the last read land, then write the new position and hand the cost over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mckj_pkg::ST_IDLE;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			items_seen_q <= '0;
			reach_q      <= '0;
			cnt_q        <= '0;
			seq_ended_q  <= 1'b0;
			rd_vld_s1    <= 1'b0;
			m_tvalid     <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			// A new result only lands when the output register is free or draining.
			if (ram_we) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				mckj_pkg::ST_IDLE: begin
					if (s_acc) begin
						items_seen_q <= seen_eff;
						reach_q      <= reach_d;
						cnt_q        <= '0;
						rd_ptr_q     <= mckj_pkg::addr_prev(wr_ptr_q);
						state_q      <= (reach_d == '0) ? mckj_pkg::ST_WRITE
						                                : mckj_pkg::ST_READ;
					end
				end
				mckj_pkg::ST_READ: begin
					rd_ptr_q <= mckj_pkg::addr_prev(rd_ptr_q);
					cnt_q    <= cnt_q + mckj_pkg::seen_t'(1);
					if (cnt_q == reach_q - mckj_pkg::seen_t'(1)) begin
						state_q <= mckj_pkg::ST_WAIT;
					end
				end
				mckj_pkg::ST_WAIT: begin
					state_q <= mckj_pkg::ST_WRITE;
				end
				mckj_pkg::ST_WRITE: begin
					if (out_free) begin
						wr_ptr_q    <= mckj_pkg::addr_next(wr_ptr_q);
						seq_ended_q <= last_q;
						if (items_seen_q != mckj_pkg::SEEN_W'(mckj_pkg::MAX_JUMP)) begin
							items_seen_q <= items_seen_q + mckj_pkg::seen_t'(1);
						end
						state_q <= mckj_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mckj_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Item payload and running minimum. The first position of a sequence costs zero.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			h_q    <= h_in;
			last_q <= s_tlast;
			best_q <= (reach_d == '0) ? '0 : '1;
		end else if (rd_vld_s1 && (cand < best_q)) begin
			best_q <= cand;
		end
		if (ram_we) begin
			out_cost_q <= best_q;
			out_last_q <= last_q;
		end
	end

`ifndef SYNTH
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mckj_pkg::ST_READ) |-> (reach_q != '0) && (cnt_q < reach_q))
		else $error("predecessor request beyond the reach of the item");

	a_data_only_when_scanning: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == mckj_pkg::ST_READ) || (state_q == mckj_pkg::ST_WAIT))
		else $error("history read data arrived outside the scan");

	a_first_costs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == mckj_pkg::ST_WRITE) && (reach_q == '0)) |-> (best_q == '0))
		else $error("position without predecessors has nonzero cost");

	a_write_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> m_tvalid && (out_cost_q == $past(best_q)))
		else $error("history write did not produce the matching result");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the streaming k-jump minimum-cost block.
`timescale 1ns / 100ps

import mckj_pkg::*;

typedef struct packed {
	cost_t cost;
	logic  last;
} cost_result_t;

// Tracks the jump-cost recurrence on its own copy of the history and checks each
// result item against the oldest predicted cost.
class jump_cost_board;
	height_t        heights_held [MAX_JUMP];
	cost_t          costs_held   [MAX_JUMP];
	int unsigned    held_count;
	logic [CFG_W-1:0] jump_reg;
	bit             seq_closed;
	cost_result_t   pending_costs [$];
	int unsigned    errors;

	function new();
		foreach (heights_held[i]) begin
			heights_held[i] = '0;
			costs_held[i]   = '0;
		end
		held_count = 0;
		jump_reg   = CFG_W'(1);
		seq_closed = 1'b0;
		errors     = 0;
	endfunction

	function void set_max_jump(input logic [CFG_W-1:0] value);
		jump_reg = value;
	endfunction

	function int unsigned outstanding();
		return pending_costs.size();
	endfunction

	// Works out the cost of one accepted height and queues it as the next expected result.
	function void note_height(input height_t h, input logic starts, input logic closes);
		int unsigned  k;
		int unsigned  reach;
		cost_t        best;
		height_t      diff;
		logic [COST_W:0] sum;
		cost_result_t res;
		if (starts || seq_closed) begin
			held_count = 0;
		end
		k = (jump_reg == '0) ? 1 : int'(jump_reg);
		if (k > MAX_JUMP) begin
			k = MAX_JUMP;
		end
		reach = (k < held_count) ? k : held_count;
		if (reach == 0) begin
			best = '0;
		end else begin
			best = '1;
			for (int unsigned j = 0; j < reach; j++) begin
				diff = (h >= heights_held[j]) ? h - heights_held[j] : heights_held[j] - h;
				sum  = {1'b0, costs_held[j]} + (COST_W + 1)'(diff);
				if (sum[COST_W]) begin
					sum[COST_W-1:0] = '1;
				end
				if (sum[COST_W-1:0] < best) begin
					best = sum[COST_W-1:0];
				end
			end
		end
		for (int i = MAX_JUMP - 1; i > 0; i--) begin
			heights_held[i] = heights_held[i-1];
			costs_held[i]   = costs_held[i-1];
		end
		heights_held[0] = h;
		costs_held[0]   = best;
		if (held_count < MAX_JUMP) begin
			held_count++;
		end
		seq_closed = closes;
		res.cost = best;
		res.last = closes;
		pending_costs.push_back(res);
	endfunction

	task report_mismatch(input string what);
		errors++;
		if (errors <= 50) begin
			$display("mismatch: %s", what);
		end
	endtask

	task check_cost(input cost_t got_cost, input logic got_last);
		cost_result_t want;
		if (pending_costs.size() == 0) begin
			report_mismatch($sformatf("result cost %0d last %0b with no item pending",
				got_cost, got_last));
			return;
		end
		want = pending_costs.pop_front();
		if (got_cost !== want.cost) begin
			report_mismatch($sformatf("min_cost %0d, expected %0d", got_cost, want.cost));
		end
		if (got_last !== want.last) begin
			report_mismatch($sformatf("is_last %0b, expected %0b", got_last, want.last));
		end
	endtask
endclass

module tb_top;

	// Cycles without any accepted item before the run is declared hung. The slowest
	// item reads all MAX_JUMP predecessors and may meet random stalls on both sides, so
	// this is far above any correct run.
	localparam int WATCHDOG_LIMIT = 4000;
	// Items per random phase; twelve phases plus the directed part give about 1900.
	localparam int PHASE_ITEMS    = 150;

	typedef enum logic [1:0] {
		SHAPE_RANDOM,
		SHAPE_WALK,
		SHAPE_EXTREME,
		SHAPE_FLAT
	} shape_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_W-1:0]        cfg_data;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata;   // height
	logic                    s_tuser;   // starts_sequence
	logic                    s_tlast;   // last_item
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;   // min_cost
	logic                    m_tlast;   // is_last

	jump_cost_board board;
	// While set, neither the sender nor the receiver inserts gaps.
	bit             no_gaps = 1'b0;
	int unsigned    stall_cycles = 0;

	// The jump register values the first ten random phases walk through, extremes first.
	// Zero must act as 1 and anything above MAX_JUMP must act as MAX_JUMP.
	logic [CFG_W-1:0] phase_jumps [10] = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd17,
		5'd2, 5'd15, 5'd8, 5'd4, 5'd7};

	min_cost_k_jump_path DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The receiver decides at each falling edge whether it will take a result at the
	// next rising edge. It stalls in about 11 of a hundred decisions.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = no_gaps || ($urandom_range(99) >= 11);
		end
	end

	// Every result item accepted at a rising edge is checked right there.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_cost(m_tdata[COST_W-1:0], m_tlast);
		end
	end

	// The watchdog restarts on any accepted item on any channel.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Next height of a sequence in the given shape. Walks stay near the previous
	// height, so long sequences keep small costs and the minimum is often decided
	// by a few counts; the extreme shape stresses the widest differences.
	function automatic height_t pick_height(input shape_t shape, input height_t prev);
		height_t h;
		case (shape)
			SHAPE_RANDOM: begin
				h = height_t'($urandom);
			end
			SHAPE_WALK: begin
				h = prev + height_t'($urandom_range(64)) - height_t'(32);
			end
			SHAPE_EXTREME: begin
				h = ($urandom_range(1) == 0) ? '0 : '1;
			end
			default: begin
				h = ($urandom_range(7) == 0) ? height_t'($urandom) : prev;
			end
		endcase
		return h;
	endfunction

	// Offers one height item and returns at the falling edge after it was accepted.
	// Idle cycles before it carry random data with tvalid low.
	task automatic send_height(input height_t h, input logic starts, input logic closes);
		while (!no_gaps && $urandom_range(99) < 11) begin
			s_tvalid = 1'b0;
			s_tdata  = IN_TDATA_W'($urandom);
			s_tuser  = 1'($urandom);
			s_tlast  = 1'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = IN_TDATA_W'(h);
		s_tuser  = starts;
		s_tlast  = closes;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		board.note_height(h, starts, closes);
		@(negedge clk);
	endtask

	// The register is only written once every expected result has come back.
	task automatic write_max_jump(input logic [CFG_W-1:0] value);
		s_tvalid = 1'b0;
		while (board.outstanding() != 0) begin
			@(negedge clk);
		end
		cfg_valid = 1'b1;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		board.set_max_jump(value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One well-formed sequence: start mark on the first item, last mark on the final one.
	task automatic send_sequence(input int unsigned len, input shape_t shape);
		height_t h;
		h = height_t'($urandom);
		for (int unsigned i = 0; i < len; i++) begin
			h = pick_height(shape, h);
			send_height(h, i == 0, i == len - 1);
		end
	endtask

	// Mostly well-formed sequences of random length and shape. The rest is noise:
	// short bursts with start and last marks at random, which gives mid-sequence
	// restarts, items after a last item without a start, and runs with no end.
	task automatic run_phase(input int unsigned budget);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(99) < 80) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 20);
				send_sequence(len, shape_t'($urandom_range(3)));
			end else begin
				len = $urandom_range(1, 6);
				repeat (len) begin
					send_height(height_t'($urandom), $urandom_range(99) < 15,
						$urandom_range(99) < 15);
				end
			end
			sent += len;
		end
	endtask

	initial begin
		height_t ramp [17];
		ramp = '{16'd0, 16'hFFFF, 16'd0, 16'd7, 16'd9, 16'd3, 16'hFFFF,
			16'd100, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'h8000};
		board     = new();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		s_tlast   = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with the register at its reset value of 1. The first item
		// carries no start mark but has nothing before it, so it costs 0. Then the
		// height extremes, an item after a last item without a start mark, and a
		// start mark in the middle of a sequence.
		send_height(16'd1234, 1'b0, 1'b0);
		send_height(16'hFFFF, 1'b0, 1'b0);
		send_height(16'd0,    1'b0, 1'b0);
		send_height(16'hFFFF, 1'b0, 1'b1);
		send_height(16'd100,  1'b0, 1'b0);
		send_height(16'd200,  1'b0, 1'b0);
		send_height(16'd300,  1'b1, 1'b0);
		send_height(16'd50,   1'b0, 1'b1);

		// Widest jump: seventeen items fill the history and push the oldest out.
		write_max_jump(CFG_W'(MAX_JUMP));
		foreach (ramp[i]) begin
			send_height(ramp[i], i == 0, i == 16);
		end

		// Random phases, each under its own jump setting. The third one runs with no
		// gaps on either side to keep the block busy back to back.
		for (int p = 0; p < 12; p++) begin
			write_max_jump((p < 10) ? phase_jumps[p] : CFG_W'($urandom));
			no_gaps = (p == 2);
			run_phase(PHASE_ITEMS);
		end
		no_gaps = 1'b0;
		s_tvalid = 1'b0;

		// Drain, then give the block time to show any result nobody asked for.
		while (board.outstanding() != 0) begin
			@(negedge clk);
		end
		repeat (MAX_JUMP + 8) @(negedge clk);
		if (board.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
